>>> rtl/double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check a property at every rising edge of clk, off while rst_n is low.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error(msg);

`endif

>>> rtl/dq_pkg.sv
// Shared constants and types of the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;
  localparam int unsigned DQ_CAPACITY = 1024;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KIND_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE       = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_BACK   = 3'd4
  } kind_t;
endpackage

>>> rtl/dq_ram.sv
// Generic simple RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module dq_ram import dq_pkg::*; #(
  parameter  int unsigned WIDTH = WORD_W,
  parameter  int unsigned DEPTH = DQ_CAPACITY,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> rtl/double_ended_queue.sv
// Double-ended queue of signed words in a ring buffer, top level.
//
// Use: raise start with in_kind and in_push_value; the operation transfers
// at the rising edge where start is high and busy is low. busy stays low,
// so one operation can transfer in every cycle.
// in_kind: none, push front, push back, pop front, pop back; other codes
// act as none. Every operation gives exactly one result.
// Results: each result passes through the step record and then the output
// registers onto the out_ ports, marked by out_valid for one cycle. Throughput
// is one operation per cycle, set by the single write port and the two
// read ports of the slot RAM (front and back are read after each step).
// Each result carries the popped word, the dropped-push flag and the queue
// state after the step: entry count, empty flag, front and back words.
// Reset (rst_n low, synchronous) empties the queue; slot contents are
// left as they are and are never read before being written.
// The receiver cannot stall: a result is gone after its one cycle.
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"
module double_ended_queue import dq_pkg::*; #(
  parameter  int unsigned CAPACITY = DQ_CAPACITY,
  localparam int unsigned IDX_W    = $clog2(CAPACITY),
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [WORD_W-1:0] in_push_value,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_popped_value,
  output logic                     out_popped_valid,
  output logic                     out_overflow,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_empty,
  output logic signed [WORD_W-1:0] out_front_value,
  output logic signed [WORD_W-1:0] out_back_value,
  output logic                     out_ends_valid
);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // Step record carried from the RAM access cycle to the result cycle.
  typedef struct packed {
    logic              pop_ok;
    logic              pop_head;
    logic              ovf;
    logic              fwd_front;
    logic              fwd_back;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] word;
  } step_t;

  // Ring state: head is the front slot, tail the slot after the back.
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             acc;
  kind_t            kind;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_front_addr, rd_back_addr;
  logic             pop_ok, pop_head, ovf;

  step_t            step_nxt, step_r;
  logic             step_valid_r;
  logic [WORD_W-1:0] rd_front_data, rd_back_data;
  logic [WORD_W-1:0] front_word, back_word, popped_word;
  logic             ends_ok;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign kind = kind_t'(in_kind);

  // Wrapping neighbors of both ends.
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;

  // Decode the operation, move the ends and pick the slot to write.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    we        = 1'b0;
    wr_addr   = tail_r;
    pop_ok    = 1'b0;
    pop_head  = 1'b0;
    ovf       = 1'b0;
    if (acc) begin
      case (kind)
        KIND_PUSH_FRONT: begin
          if (count_r == FULL_CNT) begin
            ovf = 1'b1;
          end else begin
            head_nxt  = head_dec;
            wr_addr   = head_dec;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        KIND_PUSH_BACK: begin
          if (count_r == FULL_CNT) begin
            ovf = 1'b1;
          end else begin
            tail_nxt  = tail_inc;
            wr_addr   = tail_r;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (count_r != '0) begin
            head_nxt  = head_inc;
            pop_ok    = 1'b1;
            pop_head  = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        KIND_POP_BACK: begin
          if (count_r != '0) begin
            tail_nxt  = tail_dec;
            pop_ok    = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read the new ends right away; the back word sits one slot before tail.
  assign rd_front_addr = head_nxt;
  assign rd_back_addr  = (tail_nxt == '0) ? LAST_IDX : tail_nxt - 1'b1;

  // A pushed word read in its own write cycle comes from the step record.
  always_comb begin
    step_nxt.pop_ok    = pop_ok;
    step_nxt.pop_head  = pop_head;
    step_nxt.ovf       = ovf;
    step_nxt.fwd_front = we && (wr_addr == rd_front_addr);
    step_nxt.fwd_back  = we && (wr_addr == rd_back_addr);
    step_nxt.count     = count_nxt;
    step_nxt.word      = in_push_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      step_valid_r <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      step_valid_r <= acc;
      out_valid    <= step_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .we      (we),
    .waddr   (wr_addr),
    .wdata   (in_push_value),
    .raddr_a (rd_front_addr),
    .raddr_b (rd_back_addr),
    .rdata_a (rd_front_data),
    .rdata_b (rd_back_data)
  );

  // The popped word is an end of the state before this step, which is
  // exactly what the previous result left in the output registers.
  assign ends_ok     = (step_r.count != '0);
  assign front_word  = !ends_ok ? '0 : (step_r.fwd_front ? step_r.word : rd_front_data);
  assign back_word   = !ends_ok ? '0 : (step_r.fwd_back ? step_r.word : rd_back_data);
  assign popped_word = !step_r.pop_ok ? '0 :
                       (step_r.pop_head ? out_front_value : out_back_value);

  // Hold the last result between transfers; the ends stay valid for the next pop.
  always_ff @(posedge clk) begin
    if (step_valid_r) begin
      out_popped_value <= popped_word;
      out_popped_valid <= step_r.pop_ok;
      out_overflow     <= step_r.ovf;
      out_entry_count  <= step_r.count;
      out_is_empty     <= !ends_ok;
      out_front_value  <= front_word;
      out_back_value   <= back_word;
      out_ends_valid   <= ends_ok;
    end
  end

  `DQ_ASSERT(a_count_range, count_r <= FULL_CNT, "entry count beyond capacity")
  `DQ_ASSERT(a_result_latency, acc |-> ##2 out_valid, "result missing two cycles after transfer")
  `DQ_ASSERT(a_overflow_full, out_valid && out_overflow |-> out_entry_count == FULL_CNT,
             "overflow reported while not full")
  `DQ_ASSERT_NEXT(a_push_grows,
                  acc && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK)
                  && count_r != FULL_CNT,
                  count_r == $past(count_r) + 1'b1, "accepted push did not add a word")
endmodule

>>> tb/sv/double_ended_queue_check.sv
// Transfer monitor, deque predictor and result comparison for double_ended_queue.
`timescale 1ns / 1ps
module double_ended_queue_check import dq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [WORD_W-1:0] in_push_value,
  input  logic              out_valid,
  input  logic [WORD_W-1:0] out_popped_value,
  input  logic              out_popped_valid,
  input  logic              out_overflow,
  input  logic [$clog2(DQ_CAPACITY + 1)-1:0] out_entry_count,
  input  logic              out_is_empty,
  input  logic [WORD_W-1:0] out_front_value,
  input  logic [WORD_W-1:0] out_back_value,
  input  logic              out_ends_valid,
  output int                errors,
  output int                outstanding
);

  localparam int unsigned CNT_W      = $clog2(DQ_CAPACITY + 1);

  typedef struct {
    logic [WORD_W-1:0] popped_value;
    logic              popped_valid;
    logic              overflow;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] back_value;
    logic              ends_valid;
  } deque_result_t;

  // Shadow copy of the ring and its pointers.
  logic [WORD_W-1:0] ring [DQ_CAPACITY];
  int unsigned       head_idx;
  int unsigned       word_count;
  deque_result_t     awaited_results [$];
  int unsigned       result_no;

  initial begin
    errors      = 0;
    outstanding = 0;
    result_no   = 0;
    head_idx    = 0;
    word_count  = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] result %0d: %s", $realtime, result_no, what);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, $signed(got),
                                $signed(want)));
    end
  endtask

  // Apply one operation to the shadow deque and build the result it gives.
  task automatic deque_step(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] word,
                            output deque_result_t r);
    r = '{default: '0};
    case (op)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (word_count >= DQ_CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          if (op == KIND_PUSH_FRONT) begin
            head_idx       = (head_idx + DQ_CAPACITY - 1) % DQ_CAPACITY;
            ring[head_idx] = word;
          end else begin
            ring[(head_idx + word_count) % DQ_CAPACITY] = word;
          end
          word_count++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (word_count != 0) begin
          if (op == KIND_POP_FRONT) begin
            r.popped_value = ring[head_idx];
            head_idx       = (head_idx + 1) % DQ_CAPACITY;
          end else begin
            r.popped_value = ring[(head_idx + word_count - 1) % DQ_CAPACITY];
          end
          word_count--;
          r.popped_valid = 1'b1;
        end
      end
      default: ;
    endcase
    if (word_count != 0) begin
      r.front_value = ring[head_idx];
      r.back_value  = ring[(head_idx + word_count - 1) % DQ_CAPACITY];
      r.ends_valid  = 1'b1;
    end
    r.entry_count = CNT_W'(word_count);
    r.is_empty    = (word_count == 0);
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t fresh;
    if (!rst_n) begin
      head_idx   = 0;
      word_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        result_no++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no operation outstanding");
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          check_field("popped_value", out_popped_value, want.popped_value);
          check_field("popped_valid", WORD_W'(out_popped_valid), WORD_W'(want.popped_valid));
          check_field("overflow", WORD_W'(out_overflow), WORD_W'(want.overflow));
          check_field("entry_count", WORD_W'(out_entry_count), WORD_W'(want.entry_count));
          check_field("is_empty", WORD_W'(out_is_empty), WORD_W'(want.is_empty));
          check_field("front_value", out_front_value, want.front_value);
          check_field("back_value", out_back_value, want.back_value);
          check_field("ends_valid", WORD_W'(out_ends_valid), WORD_W'(want.ends_valid));
        end
      end
      if (start && !busy) begin
        deque_step(in_kind, in_push_value, fresh);
        awaited_results = {awaited_results, fresh};
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

>>> tb/sv/double_ended_queue_tb.sv
// Top of the double_ended_queue testbench: clock, reset, operation stimulus, verdict.
`timescale 1ns / 1ps
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DQ_CAPACITY + 1);

  // Codes the block treats as no operation.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_ONES  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_ALT_A = 32'hAAAA_AAAA;
  localparam logic [WORD_W-1:0] WORD_ALT_5 = 32'h5555_5555;

  localparam int RANDOM_OPS  = 50;
  localparam int SETTLE_CYC  = 6;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind;
  logic signed [WORD_W-1:0] in_push_value;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_popped_value;
  logic                     out_popped_valid;
  logic                     out_overflow;
  logic [CNT_W-1:0]         out_entry_count;
  logic                     out_is_empty;
  logic signed [WORD_W-1:0] out_front_value;
  logic signed [WORD_W-1:0] out_back_value;
  logic                     out_ends_valid;

  int errors;
  int outstanding;
  int gap_pct;

  double_ended_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_popped_valid (out_popped_valid),
    .out_overflow     (out_overflow),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_ends_valid   (out_ends_valid)
  );

  double_ended_queue_check check_u (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_popped_valid (out_popped_valid),
    .out_overflow     (out_overflow),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_ends_valid   (out_ends_valid),
    .errors           (errors),
    .outstanding      (outstanding)
  );

  // 4 ns period: low half, then high half.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hold each operation from a falling edge until a rising edge sees busy low.
  // The caller always enters at a falling edge and leaves at one, so start
  // gets a single assignment per time step: either dropped for a gap cycle
  // or driven high with the next operation.
  task automatic send_op(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_kind       <= op;
    in_push_value <= word;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Mostly random words, with the extremes and zero mixed in.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Random mix: more pushes than pops so the depth wanders upward,
  // plus a few no-ops and spare codes.
  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 27)      return KIND_PUSH_FRONT;
    else if (r < 54) return KIND_PUSH_BACK;
    else if (r < 71) return KIND_POP_FRONT;
    else if (r < 88) return KIND_POP_BACK;
    else if (r < 94) return KIND_NONE;
    else             return KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
  endfunction

  // Push past capacity from either end: whatever depth we start at, the
  // last few pushes hit a full queue and must be dropped.
  task automatic fill_past_full();
    repeat (DQ_CAPACITY + 6) begin
      send_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = KIND_NONE;
    in_push_value = '0;
    gap_pct       = 0;

    // Synchronous reset, released on a falling edge.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: operations on an empty queue, pushes of the extreme words at
    // both ends, spare codes with four words in the queue, pops from
    // both ends down to empty and past it, a single-entry queue where front
    // and back are the same word.
    send_op(KIND_NONE,       '0);
    send_op(KIND_POP_FRONT,  WORD_ONES);
    send_op(KIND_POP_BACK,   '0);
    send_op(KIND_PUSH_FRONT, WORD_MAX);
    send_op(KIND_PUSH_BACK,  WORD_MIN);
    send_op(KIND_PUSH_FRONT, WORD_ONES);
    send_op(KIND_PUSH_BACK,  '0);
    send_op(KIND_SPARE_LO,   WORD_ALT_A);
    send_op(KIND_SPARE_MID,  WORD_ONES);
    send_op(KIND_SPARE_HI,   WORD_ALT_5);
    send_op(KIND_POP_BACK,   '0);
    send_op(KIND_POP_FRONT,  '0);
    send_op(KIND_POP_BACK,   '0);
    send_op(KIND_POP_FRONT,  '0);
    send_op(KIND_POP_FRONT,  '0);
    send_op(KIND_PUSH_BACK,  WORD_ALT_5);
    send_op(KIND_POP_FRONT,  '0);
    send_op(KIND_PUSH_FRONT, WORD_ALT_A);
    send_op(KIND_POP_BACK,   '0);
    send_op(KIND_NONE,       WORD_ONES);

    // Random phases: no gaps, heavy gaps, no gaps, light gaps. The result
    // side has no stall, so only the sender idles. The heavy-gap phase also
    // runs the queue past full, so the later phases work near full and
    // see dropped pushes mixed with pops.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       gap_pct = 56;
        3:       gap_pct = 16;
        default: gap_pct = 0;
      endcase
      repeat (RANDOM_OPS) send_op(pick_kind(), pick_word());
      if (phase == 1) fill_past_full();
    end

    // Drop start and let every result drain, then a few more cycles to
    // catch any stray strobe.
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
tb/sv/double_ended_queue_check.sv
tb/sv/double_ended_queue_tb.sv
